[rtl/u8nv_pkg.sv]
// ----------------------------------------------------------------------------
// u8nv_pkg
// Types and constants for the UTF-8 name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package u8nv_pkg;

   localparam int unsigned CountWidth = 10;
   localparam int unsigned CodeWidth  = 21;

   localparam logic [CountWidth-1:0] CountMax     = 10'd1023;
   localparam logic [CountWidth-1:0] MaxBytesRst  = 10'd256;

   localparam logic [CodeWidth-1:0]  CodeTop      = 21'h10ffff;
   localparam logic [CodeWidth-1:0]  SurrLow      = 21'h00d800;
   localparam logic [CodeWidth-1:0]  SurrHigh     = 21'h00dfff;
   localparam logic [CodeWidth-1:0]  C1Top        = 21'h00009f;

   localparam logic [7:0] AsciiSpace = 8'h20;
   localparam logic [7:0] AsciiDel   = 8'h7f;

   // lead byte class selects the smallest legal code point
   typedef enum logic [1:0] {
      CLS_TWO   = 2'd0,
      CLS_THREE = 2'd1,
      CLS_FOUR  = 2'd2,
      CLS_SPARE = 2'd3
   } overlong_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_name;
   } req_payload_type;

   typedef struct packed {
      logic name_valid;
      logic failed;
      logic name_done;
   } rsp_payload_type;

   function automatic logic [CodeWidth-1:0] min_code(input overlong_class_type cls);
      logic [CodeWidth-1:0] res;
      case (cls)
         CLS_TWO:   res = 21'h000080;
         CLS_THREE: res = 21'h000800;
         CLS_FOUR:  res = 21'h010000;
         default:   res = 21'h010000;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/utf8_name_validator.sv]
// ----------------------------------------------------------------------------
// utf8_name_validator
// Streaming UTF-8 name check, one byte per transfer, verdict per byte.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------------------
//  req     | req_valid, req_stall, req_data | in        | data_byte, end_of_name
//  rsp     | rsp_valid, rsp_stall, rsp_data | out       | name_valid, failed, done
//  csr     | csr_valid, csr_ready, csr_data | in        | max_name_bytes
//
//  One byte per cycle sustained while rsp is not stalled; each byte goes
//  through the input register, then is decoded into the result register.
//  The decode state updates only when a byte moves into the result register.
//  Synchronous reset clears all name state and sets the limit to 256.
//  A stall on rsp backs up into req_stall in the same cycle.
`default_nettype none

module utf8_name_validator (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  u8nv_pkg::req_payload_type  req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output u8nv_pkg::rsp_payload_type  rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [9:0]                  csr_data
);
   import u8nv_pkg::*;

   // input and result registers
   logic                      in_vld_ff, in_vld_in;
   req_payload_type           in_data_ff;
   logic                      out_vld_ff, out_vld_in;
   rsp_payload_type           out_data_ff, out_data_in;

   // name state
   logic [CountWidth-1:0]     max_bytes_ff;
   logic                      fail_ff, fail_in;
   logic [1:0]                pend_ff, pend_in;
   logic [CodeWidth-1:0]      acc_ff, acc_in;
   overlong_class_type        cls_ff, cls_in;
   logic [CountWidth-1:0]     count_ff, count_in;

   logic                      out_free;
   logic                      move;
   logic [7:0]                b;
   logic [CodeWidth-1:0]      code;
   logic                      fail_now;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign move      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   assign in_vld_in  = (req_valid && !req_stall) ? 1'b1 : (move ? 1'b0 : in_vld_ff);
   assign out_vld_in = move ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);

   always_comb begin
      b        = in_data_ff.data_byte;
      fail_in  = fail_ff || (count_ff >= max_bytes_ff);
      count_in = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
      pend_in  = pend_ff;
      acc_in   = acc_ff;
      cls_in   = cls_ff;
      code     = {acc_ff[CodeWidth-7:0], b[5:0]};

      if (pend_ff == 2'd0) begin
         case (b) inside
            [8'h00:8'h7f]: begin
               if (b < AsciiSpace || b == AsciiDel) fail_in = 1'b1;
            end
            [8'hc2:8'hdf]: begin
               pend_in = 2'd1;
               acc_in  = {16'd0, b[4:0]};
               cls_in  = CLS_TWO;
            end
            [8'he0:8'hef]: begin
               pend_in = 2'd2;
               acc_in  = {17'd0, b[3:0]};
               cls_in  = CLS_THREE;
            end
            [8'hf0:8'hf4]: begin
               pend_in = 2'd3;
               acc_in  = {18'd0, b[2:0]};
               cls_in  = CLS_FOUR;
            end
            default: begin
               fail_in = 1'b1;
            end
         endcase
      end else if (b[7:6] != 2'b10) begin
         fail_in = 1'b1;
         pend_in = 2'd0;
      end else begin
         acc_in  = code;
         pend_in = pend_ff - 2'd1;
         // sequence complete: range checks on the finished code point
         if (pend_ff == 2'd1) begin
            if (code < min_code(cls_ff) || code <= C1Top || code > CodeTop ||
                (code >= SurrLow && code <= SurrHigh))
               fail_in = 1'b1;
         end
      end

      fail_now = fail_in || (in_data_ff.end_of_name && pend_in != 2'd0);
      out_data_in.name_valid = !fail_now && (pend_in == 2'd0);
      out_data_in.failed     = fail_now;
      out_data_in.name_done  = in_data_ff.end_of_name;

      if (in_data_ff.end_of_name) begin
         fail_in  = 1'b0;
         pend_in  = 2'd0;
         acc_in   = '0;
         cls_in   = CLS_TWO;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         max_bytes_ff <= MaxBytesRst;
         fail_ff      <= 1'b0;
         pend_ff      <= 2'd0;
         acc_ff       <= '0;
         cls_ff       <= CLS_TWO;
         count_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid && csr_ready) max_bytes_ff <= csr_data;
         if (move) begin
            fail_ff  <= fail_in;
            pend_ff  <= pend_in;
            acc_ff   <= acc_in;
            cls_ff   <= cls_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (move)                    out_data_ff <= out_data_in;
   end

   // a valid verdict never comes with a failure
   a_valid_not_failed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.name_valid && rsp_data.failed))
      else $error("name_valid and failed both set");

   // the end of a name leaves the decoder idle
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (move && in_data_ff.end_of_name) |=> (pend_ff == 2'd0 && count_ff == '0 && !fail_ff))
      else $error("name state not cleared after last byte");

   // a held result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // a byte in the input register is never lost
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !move) |=> in_vld_ff)
      else $error("input byte dropped");

endmodule

`default_nettype wire

[tb/utf8_name_validator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_name_validator_tb
// Streams directed and random names, one byte per transfer, through the
// validator with random gaps and stalls on both channels. Each verdict is
// checked against a byte-level UTF-8 decoder kept in the bench. The run
// sweeps the length limit register, including zero and its largest value.
// ----------------------------------------------------------------------------

module utf8_name_validator_tb;
   import u8nv_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 55;
   localparam int LongName   = 260;

   localparam rsp_payload_type VerdictGood = '{1'b1, 1'b0, 1'b1};
   localparam rsp_payload_type VerdictBad  = '{1'b0, 1'b1, 1'b1};
   localparam rsp_payload_type NoVerdict   = '{1'b0, 1'b0, 1'b0};

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            last;
      logic            known;
      rsp_payload_type want;
   } name_step_type;

   localparam name_step_type DirectedSteps [23] = '{
      '{8'h41, 1'b1, 1'b1, VerdictGood},
      '{8'h00, 1'b1, 1'b1, VerdictBad},
      '{8'h7f, 1'b1, 1'b1, VerdictBad},
      '{8'h80, 1'b1, 1'b1, VerdictBad},
      '{8'hff, 1'b1, 1'b1, VerdictBad},
      // smallest legal two-byte code point
      '{8'hc2, 1'b0, 1'b0, NoVerdict},
      '{8'ha0, 1'b1, 1'b0, NoVerdict},
      // overlong three-byte form
      '{8'he0, 1'b0, 1'b0, NoVerdict},
      '{8'h9f, 1'b0, 1'b0, NoVerdict},
      '{8'hbf, 1'b1, 1'b0, NoVerdict},
      // surrogate
      '{8'hed, 1'b0, 1'b0, NoVerdict},
      '{8'ha0, 1'b0, 1'b0, NoVerdict},
      '{8'h80, 1'b1, 1'b0, NoVerdict},
      // just above the last code point
      '{8'hf4, 1'b0, 1'b0, NoVerdict},
      '{8'h90, 1'b0, 1'b0, NoVerdict},
      '{8'h80, 1'b0, 1'b0, NoVerdict},
      '{8'h80, 1'b1, 1'b0, NoVerdict},
      // C1 control
      '{8'hc2, 1'b0, 1'b0, NoVerdict},
      '{8'h80, 1'b1, 1'b0, NoVerdict},
      // sequence cut off by the end marker
      '{8'he2, 1'b0, 1'b0, NoVerdict},
      '{8'h82, 1'b1, 1'b1, VerdictBad},
      // lead byte followed by plain ASCII
      '{8'hc3, 1'b0, 1'b0, NoVerdict},
      '{8'h41, 1'b1, 1'b1, VerdictBad}
   };

   localparam logic [20:0] EdgePoints [15] = '{
      21'h00007f, 21'h000080, 21'h00009f, 21'h0000a0, 21'h0007ff,
      21'h000800, 21'h00d7ff, 21'h00d800, 21'h00dfff, 21'h00e000,
      21'h00ffff, 21'h010000, 21'h10ffff, 21'h110000, 21'h1fffff
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [9:0]      csr_data;

   // decoder state of the bench
   logic               name_bad;
   logic [1:0]         cont_left;
   logic [20:0]        code_point;
   overlong_class_type lead_class;
   logic [9:0]         bytes_seen;
   logic [9:0]         byte_limit;

   rsp_payload_type verdict_q [$];
   logic [7:0]      name_bytes [$];
   rsp_payload_type head;
   bit              calm;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   utf8_name_validator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void clear_name_state();
      name_bad   = 1'b0;
      cont_left  = 2'd0;
      code_point = '0;
      lead_class = CLS_TWO;
      bytes_seen = '0;
   endfunction

   function automatic rsp_payload_type judge_byte(input req_payload_type item);
      rsp_payload_type res;
      logic [7:0]      b;
      logic [20:0]     least;
      logic            bad_now;
      b = item.data_byte;
      if (bytes_seen >= byte_limit) name_bad = 1'b1;
      if (bytes_seen != CountMax) bytes_seen = bytes_seen + 10'd1;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            if (b < AsciiSpace || b == AsciiDel) name_bad = 1'b1;
         end else if (b >= 8'hc2 && b <= 8'hdf) begin
            cont_left  = 2'd1;
            code_point = {16'd0, b[4:0]};
            lead_class = CLS_TWO;
         end else if (b >= 8'he0 && b <= 8'hef) begin
            cont_left  = 2'd2;
            code_point = {17'd0, b[3:0]};
            lead_class = CLS_THREE;
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            cont_left  = 2'd3;
            code_point = {18'd0, b[2:0]};
            lead_class = CLS_FOUR;
         end else begin
            name_bad = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         name_bad  = 1'b1;
         cont_left = 2'd0;
      end else begin
         code_point = {code_point[14:0], b[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            case (lead_class)
               CLS_TWO:   least = 21'h000080;
               CLS_THREE: least = 21'h000800;
               default:   least = 21'h010000;
            endcase
            if (code_point < least || code_point <= C1Top || code_point > CodeTop ||
                (code_point >= SurrLow && code_point <= SurrHigh))
               name_bad = 1'b1;
         end
      end
      bad_now        = name_bad || (item.end_of_name && cont_left != 2'd0);
      res.name_valid = !bad_now && cont_left == 2'd0;
      res.failed     = bad_now;
      res.name_done  = item.end_of_name;
      if (item.end_of_name) clear_name_state();
      return res;
   endfunction

   function automatic void append_byte(input logic [7:0] value);
      name_bytes = {name_bytes, value};
   endfunction

   function automatic void encode(input logic [20:0] cp, input int len);
      case (len)
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // mostly well-formed characters, with a share of broken ones
   function automatic void add_char();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 40) begin
         append_byte(8'($urandom_range(126, 32)));
      end else if (pick < 52) begin
         encode(21'($urandom_range(32'h7ff, 32'ha0)), 2);
      end else if (pick < 64) begin
         encode(21'($urandom_range(32'hffff, 32'h800)), 3);
      end else if (pick < 74) begin
         encode(21'($urandom_range(32'h10ffff, 32'h10000)), 4);
      end else if (pick < 80) begin
         encode(EdgePoints[$urandom_range(14)], $urandom_range(4, 2));
      end else if (pick < 85) begin
         len = $urandom_range(4, 3);
         encode(21'($urandom_range(32'h10ffff, 32'h800)), len);
         repeat ($urandom_range(len - 1, 1)) void'(name_bytes.pop_back());
      end else if (pick < 90) begin
         encode(21'($urandom_range(32'h7ff, 32'ha0)), 2);
         name_bytes[name_bytes.size() - 1] =
            8'($urandom_range(1) ? $urandom_range(255, 192) : $urandom_range(127));
      end else if (pick < 95) begin
         append_byte($urandom_range(3) == 0 ? AsciiDel : 8'($urandom_range(31)));
      end else begin
         append_byte(8'($urandom_range(255)));
      end
   endfunction

   function automatic void make_name();
      int chars;
      name_bytes.delete();
      chars = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      repeat (chars) add_char();
   endfunction

   task automatic push_byte(input logic [7:0] value, input logic last,
                            input logic known, input rsp_payload_type want);
      req_payload_type item;
      rsp_payload_type verdict;
      item.data_byte   = value;
      item.end_of_name = last;
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdict = judge_byte(item);
      verdict_q = {verdict_q, known ? want : verdict};
   endtask

   task automatic send_name();
      foreach (name_bytes[i])
         push_byte(name_bytes[i], i == name_bytes.size() - 1, 1'b0, NoVerdict);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [9:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      byte_limit = value;
   endtask

   initial begin
      int         n;
      logic [9:0] lim;
      bit         paused;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      calm      = 1'b0;
      paused    = 1'b0;
      byte_limit = MaxBytesRst;
      clear_name_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedSteps[i])
         push_byte(DirectedSteps[i].data_byte, DirectedSteps[i].last,
                   DirectedSteps[i].known, DirectedSteps[i].want);

      // one name just past the reset limit, sent with no gaps
      set_limit(MaxBytesRst);
      calm = 1'b1;
      for (int i = 0; i < LongName; i++)
         push_byte(8'($urandom_range(126, 32)), i == LongName - 1, 1'b0, NoVerdict);
      calm = 1'b0;

      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       lim = 10'd1;
            1:       lim = 10'd0;
            2:       lim = 10'd3;
            3:       lim = CountMax;
            4:       lim = 10'($urandom_range(40, 2));
            5:       lim = 10'($urandom_range(1022, 41));
            default: lim = MaxBytesRst;
         endcase
         set_limit(lim);
         calm = (p == 3);
         n = 0;
         while (n < PhaseItems) begin
            make_name();
            n += name_bytes.size();
            send_name();
            // hold the sender until every verdict is back
            if (p == 6 && !paused && n >= PhaseItems / 2) begin
               paused = 1'b1;
               drain_results();
            end
         end
      end
      calm = 1'b0;
      drain_results();

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: valid=%0b failed=%0b done=%0b",
                        rsp_data.name_valid, rsp_data.failed, rsp_data.name_done);
         end else begin
            head = verdict_q.pop_front();
            if (rsp_data.name_valid !== head.name_valid || rsp_data.failed !== head.failed ||
                rsp_data.name_done !== head.name_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("verdict mismatch: expected valid=%0b failed=%0b done=%0b, %s",
                           head.name_valid, head.failed, head.name_done,
                           $sformatf("got valid=%0b failed=%0b done=%0b",
                                     rsp_data.name_valid, rsp_data.failed,
                                     rsp_data.name_done));
            end
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 27);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
